// ----- src/sftb_pkg.sv -----
// Shared types and codes of the sparse fiber tree builder.
// No dependencies; imported by the level cell and the top level.
package sftb_pkg;

    // record kinds on the result stream
    localparam logic [1:0] KIND_FIBER = 2'd0;
    localparam logic [1:0] KIND_LEAF  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // fixed field widths of the stream payloads
    localparam int IN_COORD_W  = 32;
    localparam int OUT_COORD_W = 32;
    localparam int OUT_CHILD_W = 32;
    localparam int VALUE_W     = 64;
    localparam int LEVEL_W     = 3;
    localparam int MODES_W     = 3;

    // strobes from the sequencer to every level cell
    typedef struct packed {
        logic load;   // new nonzero transfer: take coordinate, place token
        logic shift;  // move the token one cell deeper
        logic bump;   // token holder counts one more fiber
        logic clear;  // end of tensor: drop counts and token
    } t_cell_ctl;

endpackage

// ----- src/sparse_fiber_tree_builder.sv -----
// Top level of the compressed sparse fiber tree builder.
// Depends on sftb_pkg and sftb_level_cell.
//
// Nonzeros arrive sorted in level order; for each one the block emits a fiber
// start record for every inner level from the shallowest changed level down,
// then the leaf record, and after the final nonzero one end pointer record per
// inner level, after which all counts return to zero. Timing: a nonzero is
// taken, then records leave one per cycle while the output is not stalled; no
// new nonzero is taken until the last record of the item is registered. The
// token walks the row of level cells, one level per cycle when not stalled,
// feeding the single output register. modes_in_use is written through the cfg
// channel; the user must write it only while idle (not enforced by the block).
module sparse_fiber_tree_builder
    import sftb_pkg::*;
#(
    parameter int MAX_LEVELS  = 6,
    parameter int COORD_WIDTH = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration: modes_in_use
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_data,
    // nonzero stream
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // coord_level0..coord_level5 (32 each), nonzero_value (64)
    input  logic [255:0]   s_axis_tdata,
    input  logic           s_axis_tlast,    // final_nonzero
    // record stream
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // tree_level (3), fiber_coord (32), child_pointer (32), leaf_value (64), zero pad (5)
    output logic [135:0]   m_axis_tdata,
    output logic [1:0]     m_axis_tuser,    // record_kind
    output logic           m_axis_tlast     // run_end
);

    localparam int LW       = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int TOP_LVLS = (MAX_LEVELS < 6) ? MAX_LEVELS : 6;

    // sequencer phases
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FIBER = 2'd1;
    localparam logic [1:0] ST_LEAF  = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    logic [MODES_W-1:0]     r_modes;
    logic [1:0]             r_state, n_state;
    logic                   r_awaiting;
    logic                   r_final;
    logic [VALUE_W-1:0]     r_value;
    logic [COUNT_WIDTH-1:0] r_nz;

    logic                   r_o_valid;
    logic [1:0]             r_o_kind;
    logic [LEVEL_W-1:0]     r_o_level;
    logic [OUT_COORD_W-1:0] r_o_coord;
    logic [OUT_CHILD_W-1:0] r_o_child;
    logic [VALUE_W-1:0]     r_o_value;
    logic                   r_o_last;

    logic [LEVEL_W-1:0]     w_levels;
    logic [LEVEL_W-1:0]     w_inner;
    logic                   w_accept;
    logic                   w_adv;
    logic                   w_tok_at_end;
    t_cell_ctl              w_ctl;
    logic                   w_seed;

    logic [MAX_LEVELS:0]    w_chg;
    logic [MAX_LEVELS:0]    w_tok;
    logic [COUNT_WIDTH-1:0] w_cnt   [MAX_LEVELS];
    logic [COORD_WIDTH-1:0] w_prev  [MAX_LEVELS];
    logic [COORD_WIDTH-1:0] w_rcrd  [MAX_LEVELS];
    logic [COUNT_WIDTH-1:0] w_rchd  [MAX_LEVELS];
    logic [COUNT_WIDTH-1:0] w_child [MAX_LEVELS];
    logic [COORD_WIDTH-1:0] w_coord [MAX_LEVELS];

    logic [COORD_WIDTH-1:0] w_fib_coord;
    logic [COUNT_WIDTH-1:0] w_fib_child;
    logic [LEVEL_W-1:0]     w_tok_level;

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modes <= MODES_W'(3);
        end else if (i_cfg_valid) begin
            r_modes <= i_cfg_data;
        end
    end

    // effective number of levels, clamped to the supported range
    always_comb begin
        w_levels = r_modes;
        if (w_levels < LEVEL_W'(2)) begin
            w_levels = LEVEL_W'(2);
        end
        if (w_levels > LEVEL_W'(TOP_LVLS)) begin
            w_levels = LEVEL_W'(TOP_LVLS);
        end
    end
    assign w_inner = w_levels - 1'b1;

    // handshakes; the deepest inner level is cell w_inner - 1, its token is w_tok[w_inner]
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_adv         = ~r_o_valid | m_axis_tready;
    assign w_tok_at_end  = w_tok[w_inner];

    // row of level cells
    assign w_chg[0] = 1'b0;
    assign w_tok[0] = w_seed;

    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
        assign w_coord[g] = COORD_WIDTH'(s_axis_tdata[g*IN_COORD_W +: IN_COORD_W]);
        if (g + 1 < MAX_LEVELS) begin : g_mid
            assign w_child[g] = (LEVEL_W'(g + 1) < w_inner) ? w_cnt[g+1] : r_nz;
        end else begin : g_deep
            assign w_child[g] = r_nz;
        end

        sftb_level_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_coord     (w_coord[g]),
            .i_inner     (LEVEL_W'(g) < w_inner),
            .i_first     ((g == 0) ? r_awaiting : 1'b0),
            .i_chg       (w_chg[g]),
            .i_tok       (w_tok[g]),
            .i_child     (w_child[g]),
            .o_chg       (w_chg[g+1]),
            .o_tok       (w_tok[g+1]),
            .o_cnt       (w_cnt[g]),
            .o_prev      (w_prev[g]),
            .o_rec_coord (w_rcrd[g]),
            .o_rec_child (w_rchd[g])
        );
    end

    // merge the token holder's record fields
    always_comb begin
        w_fib_coord = '0;
        w_fib_child = '0;
        w_tok_level = '0;
        for (int k = 0; k < MAX_LEVELS; k++) begin
            w_fib_coord = w_fib_coord | w_rcrd[k];
            w_fib_child = w_fib_child | w_rchd[k];
            if (w_tok[k+1]) begin
                w_tok_level = w_tok_level | LEVEL_W'(k);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        w_ctl      = '0;
        w_seed     = 1'b0;
        w_ctl.load = w_accept;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_chg[MAX_LEVELS] ? ST_FIBER : ST_LEAF;
                end
            end
            ST_FIBER: begin
                if (w_adv) begin
                    w_ctl.shift = 1'b1;
                    w_ctl.bump  = 1'b1;
                    if (w_tok_at_end) begin
                        n_state = ST_LEAF;
                    end
                end
            end
            ST_LEAF: begin
                if (w_adv) begin
                    if (r_final) begin
                        w_ctl.shift = 1'b1;
                        w_seed      = 1'b1;
                        n_state     = ST_END;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_END: begin
                if (w_adv) begin
                    w_ctl.shift = 1'b1;
                    if (w_tok_at_end) begin
                        w_ctl.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_awaiting <= 1'b1;
            r_nz       <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_awaiting <= 1'b0;
            end else if (w_ctl.clear) begin
                r_awaiting <= 1'b1;
            end
            if (w_ctl.clear) begin
                r_nz <= '0;
            end else if (r_state == ST_LEAF && w_adv) begin
                r_nz <= r_nz + 1'b1;
            end
        end
    end

    // held payload of the nonzero in flight
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= s_axis_tdata[6*IN_COORD_W +: VALUE_W];
            r_final <= s_axis_tlast;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= (r_state != ST_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            case (r_state)
                ST_FIBER: begin
                    r_o_kind  <= KIND_FIBER;
                    r_o_level <= w_tok_level;
                    r_o_coord <= OUT_COORD_W'(w_fib_coord);
                    r_o_child <= OUT_CHILD_W'(w_fib_child);
                    r_o_value <= '0;
                    r_o_last  <= 1'b0;
                end
                ST_LEAF: begin
                    r_o_kind  <= KIND_LEAF;
                    r_o_level <= w_inner;
                    r_o_coord <= OUT_COORD_W'(w_prev[w_inner[LW-1:0]]);
                    r_o_child <= OUT_CHILD_W'(r_nz);
                    r_o_value <= r_value;
                    r_o_last  <= ~r_final;
                end
                ST_END: begin
                    r_o_kind  <= KIND_END;
                    r_o_level <= w_tok_level;
                    r_o_coord <= '0;
                    r_o_child <= OUT_CHILD_W'(w_fib_child);
                    r_o_value <= '0;
                    r_o_last  <= w_tok_at_end;
                end
                default: begin
                    r_o_last <= r_o_last;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {5'd0, r_o_value, r_o_child, r_o_coord, r_o_level};

`ifndef SYNTHESIS
    // at most one level holds the token
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok[MAX_LEVELS:1]))
        else $error("more than one level cell holds the token");

    // walking phases always have a token holder
    a_token_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIBER || r_state == ST_END) |-> (w_tok[MAX_LEVELS:1] != '0))
        else $error("fiber or end phase without a token");

    // an accepted nonzero always starts a run of records
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after a nonzero transfer");

    // a fiber record never closes a run
    a_fiber_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_FIBER) |-> !m_axis_tlast)
        else $error("fiber record marked as last of its run");
`endif

endmodule

// ----- src/sftb_level_cell.sv -----
// One tree level of the builder: previous coordinate, fiber count and token.
// Depends on sftb_pkg; chained by sparse_fiber_tree_builder.
module sftb_level_cell
    import sftb_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic [COORD_WIDTH-1:0] i_coord,   // coordinate of the new nonzero
    input  logic                   i_inner,   // this level is an inner level
    input  logic                   i_first,   // first nonzero of a tensor (level 0 only)
    input  logic                   i_chg,     // a shallower level changed
    input  logic                   i_tok,     // token from the shallower neighbor
    input  logic [COUNT_WIDTH-1:0] i_child,   // deeper neighbor count or nonzero index
    output logic                   o_chg,
    output logic                   o_tok,
    output logic [COUNT_WIDTH-1:0] o_cnt,
    output logic [COORD_WIDTH-1:0] o_prev,
    output logic [COORD_WIDTH-1:0] o_rec_coord,
    output logic [COUNT_WIDTH-1:0] o_rec_child
);

    logic [COORD_WIDTH-1:0] r_prev;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic                   r_tok;
    logic                   w_diff;
    logic                   w_start;

    // change detection against the previous nonzero, rippled down the row
    assign w_diff  = i_inner & ((r_prev != i_coord) | i_first);
    assign o_chg   = i_chg | w_diff;
    assign w_start = w_diff & ~i_chg;

    // previous coordinate
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prev <= i_coord;
        end
    end

    // fiber count and token; the token never leaves the inner levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_tok <= 1'b0;
        end else if (i_ctl.clear) begin
            r_cnt <= '0;
            r_tok <= 1'b0;
        end else begin
            if (i_ctl.bump && r_tok) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_ctl.load) begin
                r_tok <= w_start;
            end else if (i_ctl.shift) begin
                r_tok <= i_tok & i_inner;
            end
        end
    end

    // record contribution, zero unless this cell holds the token
    assign o_rec_coord = r_tok ? r_prev  : '0;
    assign o_rec_child = r_tok ? i_child : '0;
    assign o_tok       = r_tok;
    assign o_cnt       = r_cnt;
    assign o_prev      = r_prev;

endmodule

// ----- tb/sparse_fiber_tree_builder_test.sv -----
// Self-checking testbench for the sparse fiber tree builder: drives mostly sorted nonzero
// streams under several modes_in_use settings and checks every record it emits.
// Depends on sftb_pkg and the sparse_fiber_tree_builder RTL.
module sparse_fiber_tree_builder_test
    import sftb_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEVELS   = 6;
    localparam int SETTLE_TICKS = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int SHOW_LIMIT   = 10;

    typedef struct {
        logic [5:0][31:0] coord;
        logic [63:0]      value;
        logic             last;
    } nonzero_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  level;
        logic [31:0] coord;
        logic [31:0] child;
        logic [63:0] value;
        logic        run_end;
    } tree_record_t;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_valid   = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_data    = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata  = '0;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    sparse_fiber_tree_builder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // pending nonzeros and the records they are expected to produce
    nonzero_t     nonzero_q[$];
    tree_record_t record_q[$];
    nonzero_t     cur_nonzero;

    // shadow of the tree builder state
    logic [2:0]  modes_cfg = 3'd3;
    logic [31:0] prev_coord [NUM_LEVELS];
    logic [31:0] fiber_count [NUM_LEVELS];
    logic [31:0] nz_index;
    bit          tensor_open;

    // generator view of the last coordinates queued
    logic [5:0][31:0] stream_prev = '0;

    int fault_count  = 0;
    int items_taken  = 0;
    int records_seen = 0;
    int stall_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // number of inner levels for the current setting, clamped to 2..6 modes
    function automatic int active_inner();
        int lv;
        lv = modes_cfg;
        if (lv < 2) lv = 2;
        if (lv > NUM_LEVELS) lv = NUM_LEVELS;
        return lv - 1;
    endfunction

    function automatic void clear_tree_state();
        int l;
        for (l = 0; l < NUM_LEVELS; l++) begin
            prev_coord[l]  = '0;
            fiber_count[l] = '0;
        end
        nz_index    = '0;
        tensor_open = 1'b0;
    endfunction

    function automatic tree_record_t make_record(logic [1:0] kind, int level,
            logic [31:0] coord, logic [31:0] child, logic [63:0] value);
        tree_record_t rec;
        rec.kind    = kind;
        rec.level   = 3'(level);
        rec.coord   = coord;
        rec.child   = child;
        rec.value   = value;
        rec.run_end = 1'b0;
        return rec;
    endfunction

    // expected records for one accepted nonzero
    function automatic void build_fiber_records(nonzero_t nz);
        int inner, first_lv, l;
        logic [31:0] child;
        inner    = active_inner();
        first_lv = inner;
        if (!tensor_open) begin
            first_lv = 0;
        end else begin
            for (l = 0; l < inner; l++) begin
                if (nz.coord[l] != prev_coord[l]) begin
                    first_lv = l;
                    break;
                end
            end
        end
        // fiber starts from the shallowest changed level down
        for (l = first_lv; l < inner; l++) begin
            child = (l + 1 < inner) ? fiber_count[l + 1] : nz_index;
            record_q.push_back(make_record(KIND_FIBER, l, nz.coord[l], child, '0));
            fiber_count[l] = fiber_count[l] + 1;
        end
        record_q.push_back(make_record(KIND_LEAF, inner, nz.coord[inner], nz_index,
                                       nz.value));
        nz_index = nz_index + 1;
        for (l = 0; l < NUM_LEVELS; l++)
            prev_coord[l] = nz.coord[l];
        tensor_open = 1'b1;
        // end of tensor: level totals, then start over
        if (nz.last) begin
            for (l = 0; l < inner; l++) begin
                child = (l + 1 < inner) ? fiber_count[l + 1] : nz_index;
                record_q.push_back(make_record(KIND_END, l, '0, child, '0));
            end
            clear_tree_state();
        end
        record_q[record_q.size() - 1].run_end = 1'b1;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return 32'($urandom_range(0, 15));
            1:       return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // well-formed nonzero: levels above the change level repeat the previous item
    function automatic nonzero_t make_nonzero(int change, bit last);
        nonzero_t nz;
        int l;
        for (l = 0; l < NUM_LEVELS; l++)
            nz.coord[l] = (l < change) ? stream_prev[l] : pick_coord();
        if (nz.coord[change] == stream_prev[change])
            nz.coord[change] = nz.coord[change] ^ 32'h1;
        nz.value = pick_value();
        nz.last  = last;
        return nz;
    endfunction

    function automatic nonzero_t noise_nonzero();
        nonzero_t nz;
        int l;
        for (l = 0; l < NUM_LEVELS; l++)
            nz.coord[l] = pick_coord();
        nz.value = pick_value();
        nz.last  = ($urandom_range(0, 7) == 0);
        return nz;
    endfunction

    function automatic void push_nonzero(nonzero_t nz);
        nonzero_q.push_back(nz);
        stream_prev = nz.coord;
    endfunction

    // wait until the sender is empty and every expected record has arrived
    task automatic wait_drain();
        do @(negedge i_clk);
        while (nonzero_q.size() != 0 || s_axis_tvalid || record_q.size() != 0);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic write_modes(logic [2:0] modes);
        wait_drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= modes;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        modes_cfg = modes;
    endtask

    // stimulus: directed cases, then random phases under several settings
    initial begin
        nonzero_t nz;
        int ph, made, nnz, k, inner;
        bit closing, drained;
        clear_tree_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: single-nonzero tensor of zeros, then all ones
        nz.coord = '0;
        nz.value = '0;
        nz.last  = 1'b1;
        push_nonzero(nz);
        nz.coord = '1;
        nz.value = '1;
        nz.last  = 1'b0;
        push_nonzero(nz);
        // duplicate nonzero: inner coordinates unchanged
        nz.coord[2] = 32'h0;
        nz.value    = 64'h1;
        push_nonzero(nz);
        nz.coord[1] = 32'h7;
        push_nonzero(nz);
        nz.coord[0] = 32'h0;
        nz.last     = 1'b1;
        push_nonzero(nz);

        // setting below range acts as two modes
        write_modes(3'd0);
        push_nonzero(make_nonzero(0, 1'b0));
        push_nonzero(make_nonzero(1, 1'b0));
        push_nonzero(make_nonzero(0, 1'b1));
        write_modes(3'd1);
        push_nonzero(make_nonzero(0, 1'b0));
        push_nonzero(make_nonzero(0, 1'b1));

        // setting above range acts as six modes
        write_modes(3'd7);
        push_nonzero(make_nonzero(0, 1'b0));
        push_nonzero(make_nonzero(4, 1'b0));
        push_nonzero(make_nonzero(5, 1'b0));
        push_nonzero(make_nonzero(1, 1'b0));
        push_nonzero(make_nonzero(3, 1'b1));

        // setting changed in the middle of a tensor
        write_modes(3'd5);
        push_nonzero(make_nonzero(0, 1'b0));
        push_nonzero(make_nonzero(2, 1'b0));
        push_nonzero(make_nonzero(1, 1'b0));
        write_modes(3'd2);
        push_nonzero(make_nonzero(1, 1'b0));
        push_nonzero(make_nonzero(0, 1'b1));

        // random phases, mostly well-formed tensors with some noise
        for (ph = 0; ph < 6; ph++) begin
            write_modes(ph == 0 ? 3'd6 : ph == 1 ? 3'd2 : 3'($urandom_range(0, 7)));
            inner   = active_inner();
            made    = 0;
            drained = 1'b0;
            while (made < 48) begin
                // sender holds off once per phase until all records are back
                if (made >= 24 && !drained) begin
                    wait_drain();
                    drained = 1'b1;
                end
                if ($urandom_range(0, 99) < 12) begin
                    push_nonzero(noise_nonzero());
                    made++;
                end else begin
                    nnz     = $urandom_range(1, 10);
                    closing = ($urandom_range(0, 99) < 85);
                    for (k = 0; k < nnz; k++) begin
                        push_nonzero(make_nonzero(k == 0 ? 0 : $urandom_range(0, inner),
                                                  closing && k == nnz - 1));
                        made++;
                    end
                end
            end
        end

        wait_drain();
        if (record_q.size() != 0) begin
            fault_count++;
            $display("%0d expected records never arrived", record_q.size());
        end
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // nonzero driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                build_fiber_records(cur_nonzero);
                items_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (nonzero_q.size() != 0 &&
                    ((items_taken >= 120 && items_taken < 170) ||
                     $urandom_range(0, 99) >= 36)) begin
                    cur_nonzero = nonzero_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_nonzero.value, cur_nonzero.coord};
                    s_axis_tlast  <= cur_nonzero.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // record monitor and checker
    always @(posedge i_clk) begin : record_check
        tree_record_t got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind    = m_axis_tuser;
                got.level   = m_axis_tdata[2:0];
                got.coord   = m_axis_tdata[34:3];
                got.child   = m_axis_tdata[66:35];
                got.value   = m_axis_tdata[130:67];
                got.run_end = m_axis_tlast;
                if (record_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display("record %0d arrived with none expected: kind %0d level %0d",
                                 records_seen, got.kind, got.level);
                end else begin
                    want = record_q.pop_front();
                    if (got.kind !== want.kind || got.level !== want.level ||
                        got.coord !== want.coord || got.child !== want.child ||
                        got.value !== want.value || got.run_end !== want.run_end) begin
                        fault_count++;
                        if (fault_count <= SHOW_LIMIT)
                            $display("record %0d mismatch: exp kind %0d lvl %0d coord %h",
                                     records_seen, want.kind, want.level, want.coord,
                                     " child %h value %h end %0b / got kind %0d lvl %0d",
                                     want.child, want.value, want.run_end, got.kind,
                                     got.level, " coord %h child %h value %h end %0b",
                                     got.coord, got.child, got.value, got.run_end);
                    end
                end
                records_seen++;
            end
            m_axis_tready <= (records_seen >= 300 && records_seen < 420) ||
                             $urandom_range(0, 99) >= 36;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
src/sftb_pkg.sv
src/sftb_level_cell.sv
src/sparse_fiber_tree_builder.sv
tb/sparse_fiber_tree_builder_test.sv
